[rtl/dsa_pkg.sv]
package dsa_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Field widths of the item channels
  localparam int CMD_W    = 2;
  localparam int FD_W     = 8;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

endpackage

[rtl/dsa_if.sv]
// Request channel: one command item
interface dsa_req_if;
  import dsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [FD_W-1:0]     fd;
  logic [HANDLE_W-1:0] handle_in;

  modport source (output valid, cmd, fd, handle_in, input ready);
  modport sink   (input valid, cmd, fd, handle_in, output ready);
endinterface

// Response channel: one result item
interface dsa_rsp_if;
  import dsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FD_W-1:0]     fd_out;
  logic [HANDLE_W-1:0] handle_out;

  modport source (output valid, status, fd_out, handle_out, input ready);
  modport sink   (input valid, status, fd_out, handle_out, output ready);
endinterface

[rtl/descriptor_slot_allocator_core.sv]
// Descriptor slot allocator. A table of SLOTS descriptor slots, each holding a
// 32-bit handle and a valid bit. Allocate stores handle_in in the first empty
// slot found by a circular search starting at the first-free hint and returns
// that slot in fd_out; remove empties slot fd and returns its old handle; get
// returns the handle of slot fd. One result item is given for every request
// item. The block works on one item at a time and takes a new request only
// once the previous result has been taken or is being taken. A single
// incrementer and compare steps the search one slot per clock, looking at up to
// SLOTS slots from the hint before an allocate gives its result; remove and get
// make one registered read of the handle store; a full table or an unused
// command is answered straight from the idle state.
// The valid bits are cleared at reset; no clearing pass is needed.
module descriptor_slot_allocator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsa_req_if.sink   req,
  dsa_rsp_if.source rsp
);
  import dsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH
  } state_e;

  state_e              state_q, state_d;
  logic [SLOTS-1:0]    valid_q, valid_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]    hint_q, hint_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [FD_W-1:0]     fd_q, fd_d;
  logic                range_ok_q, range_ok_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [FD_W-1:0]     fd_out_q, fd_out_d;
  logic [HANDLE_W-1:0] handle_out_q, handle_out_d;

  // Handle store
  logic [HANDLE_W-1:0] mem_q [SLOTS];
  logic [HANDLE_W-1:0] rd_q;
  logic                mem_we;
  logic [SLOT_W-1:0]   slot_sel;

  logic                accept;
  logic [SLOT_W-1:0]   start_idx;
  logic [SLOT_W-1:0]   fd_idx;
  logic                fetch_ok;

  assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid      = rsp_valid_q;
  assign rsp.status     = status_q;
  assign rsp.fd_out     = fd_out_q;
  assign rsp.handle_out = handle_out_q;

  // Hint taken modulo SLOTS: it only ever reaches SLOTS itself
  assign start_idx = (hint_q == CNT_W'(SLOTS)) ? '0 : hint_q[SLOT_W-1:0];
  assign fd_idx    = fd_q[SLOT_W-1:0];
  assign fetch_ok  = range_ok_q && valid_q[fd_idx];
  assign slot_sel  = (state_q == S_SCAN) ? idx_q : req.fd[SLOT_W-1:0];

  // Sequencer and next values
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    used_d       = used_q;
    hint_d       = hint_q;
    idx_d        = idx_q;
    step_d       = step_q;
    cmd_d        = cmd_q;
    fd_d         = fd_q;
    range_ok_d   = range_ok_q;
    handle_d     = handle_q;
    rsp_valid_d  = rsp_valid_q && !rsp.ready;
    status_d     = status_q;
    fd_out_d     = fd_out_q;
    handle_out_d = handle_out_q;
    mem_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d      = req.cmd;
          fd_d       = req.fd;
          range_ok_d = ({1'b0, req.fd} < (FD_W + 1)'(SLOTS));
          handle_d   = req.handle_in;
          case (req.cmd)
            CMD_ALLOC: begin
              if (used_q >= CNT_W'(SLOTS)) begin
                rsp_valid_d  = 1'b1;
                status_d     = ST_FULL;
                fd_out_d     = '0;
                handle_out_d = '0;
              end else begin
                idx_d   = start_idx;
                step_d  = '0;
                state_d = S_SCAN;
              end
            end
            CMD_REMOVE, CMD_GET: begin
              state_d = S_FETCH;
            end
            default: begin
              rsp_valid_d  = 1'b1;
              status_d     = ST_INVALID;
              fd_out_d     = '0;
              handle_out_d = '0;
            end
          endcase
        end
      end

      // One slot looked at per cycle
      S_SCAN: begin
        if (!valid_q[idx_q]) begin
          mem_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          hint_d         = CNT_W'(idx_q) + CNT_W'(1);
          used_d         = used_q + CNT_W'(1);
          rsp_valid_d    = 1'b1;
          status_d       = ST_OK;
          fd_out_d       = FD_W'(idx_q);
          handle_out_d   = '0;
          state_d        = S_IDLE;
        end else if (step_q == CNT_W'(SLOTS - 1)) begin
          rsp_valid_d  = 1'b1;
          status_d     = ST_FULL;
          fd_out_d     = '0;
          handle_out_d = '0;
          state_d      = S_IDLE;
        end else begin
          idx_d  = (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : idx_q + SLOT_W'(1);
          step_d = step_q + CNT_W'(1);
        end
      end

      // Handle read back; check and answer
      S_FETCH: begin
        rsp_valid_d = 1'b1;
        fd_out_d    = '0;
        state_d     = S_IDLE;
        if (fetch_ok) begin
          status_d     = ST_OK;
          handle_out_d = rd_q;
          if (cmd_q == CMD_REMOVE) begin
            valid_d[fd_idx] = 1'b0;
            if (CNT_W'(fd_idx) < hint_q) begin
              hint_d = CNT_W'(fd_idx);
            end
            if (used_q != '0) begin
              used_d = used_q - CNT_W'(1);
            end
          end
        end else begin
          status_d     = ST_INVALID;
          handle_out_d = '0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      used_q      <= '0;
      hint_q      <= '0;
      rsp_valid_q <= 1'b0;
      idx_q       <= '0;
      step_q      <= '0;
      cmd_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      used_q      <= used_d;
      hint_q      <= hint_d;
      rsp_valid_q <= rsp_valid_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      cmd_q       <= cmd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fd_q         <= fd_d;
    range_ok_q   <= range_ok_d;
    handle_q     <= handle_d;
    status_q     <= status_d;
    fd_out_q     <= fd_out_d;
    handle_out_q <= handle_out_d;
  end

  // Handle store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_sel] <= handle_q;
    end
    rd_q <= mem_q[slot_sel];
  end

endmodule
